// ===== src/serial_frame_receiver_top_macros.svh =====
// ----------------------------------------------------------------------------
// Serial frame receiver assertion macros
// Concurrent assertion shorthands used by the port checker file.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_TOP_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, inactive during reset.
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("serial frame receiver: same-cycle check failed");

// Next-cycle implication, inactive during reset.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("serial frame receiver: next-cycle check failed");

`endif

// ===== src/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Shared codes, constants and structs of the frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Input transaction kinds; code 3 carries no meaning and is dropped
    typedef enum logic [1:0] {
        REQ_BYTE = 2'd0,
        REQ_TICK = 2'd1,
        REQ_SENT = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_IGNORED  = 3'd1,
        EV_STORED   = 3'd2,
        EV_GOOD     = 3'd3,
        EV_BAD_VER  = 3'd4,
        EV_BAD_CSUM = 3'd5,
        EV_TOO_LONG = 3'd6,
        EV_TIMEOUT  = 3'd7
    } event_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_BYTE  = 2'd0;
    localparam logic [1:0] CFG_PROTO_MAJOR = 2'd1;
    localparam logic [1:0] CFG_PROTO_MINOR = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_MS  = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Header layout
    localparam int HEADER_BYTES = 5;
    localparam int POS_FLAGS    = 1;
    localparam int POS_MAJOR    = 2;
    localparam int POS_MINOR    = 3;
    localparam int POS_LENGTH   = 4;

    localparam int          TICK_W   = 17;
    localparam logic [16:0] TICK_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  proto_major;
        logic [7:0]  proto_minor;
        logic [15:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] data_byte;
        logic [5:0] byte_position;
        logic [7:0] frame_flags;
        logic [5:0] frame_length;
        logic       waiting_response;
        logic       response_pending;
        logic       response_timed_out;
    } res_t;

endpackage

// ===== src/sfr_channels.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver channels
// Valid/ready interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface sfr_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface sfr_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic [5:0] byte_position;
    logic [7:0] frame_flags;
    logic [5:0] frame_length;
    logic       waiting_response;
    logic       response_pending;
    logic       response_timed_out;

    modport source (
        output valid, output event_res, output data_byte, output byte_position,
        output frame_flags, output frame_length, output waiting_response,
        output response_pending, output response_timed_out, input ready
    );
    modport sink (
        input valid, input event_res, input data_byte, input byte_position,
        input frame_flags, input frame_length, input waiting_response,
        input response_pending, input response_timed_out, output ready
    );
endinterface

// ===== src/sfr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver configuration registers
// Write-only register file for start byte, version and timeout.
// ----------------------------------------------------------------------------
module sfr_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]     wr_data,
    output sfr_pkg::cfg_t                      cfg
);

    sfr_pkg::cfg_t cfg_reg;
    sfr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                sfr_pkg::CFG_START_BYTE:  cfg_next.start_byte  = wr_data[7:0];
                sfr_pkg::CFG_PROTO_MAJOR: cfg_next.proto_major = wr_data[7:0];
                sfr_pkg::CFG_PROTO_MINOR: cfg_next.proto_minor = wr_data[7:0];
                sfr_pkg::CFG_TIMEOUT_MS:  cfg_next.timeout_ms  = wr_data[15:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte  <= 8'd252;
            cfg_reg.proto_major <= 8'd0;
            cfg_reg.proto_minor <= 8'd0;
            cfg_reg.timeout_ms  <= 16'd1000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/sfr_frame_engine.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver frame engine
// Frame state registers and the one-step update for a registered item.
// ----------------------------------------------------------------------------
module sfr_frame_engine #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  logic [1:0]    req_type,
    input  logic [7:0]    rx_byte,
    input  sfr_pkg::cfg_t cfg,
    output sfr_pkg::res_t res
);

    localparam int         IDX_W   = $clog2(MAX_PAYLOAD + sfr_pkg::HEADER_BYTES + 1);
    localparam int         EXT_W   = 9;
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic [IDX_W-1:0]          idx_reg,    idx_next;
    logic [7:0]                sum_reg,    sum_next;
    logic [7:0]                flags_reg,  flags_next;
    logic [7:0]                major_reg,  major_next;
    logic [7:0]                minor_reg,  minor_next;
    logic [7:0]                length_reg, length_next;
    logic [sfr_pkg::TICK_W-1:0] idle_reg,  idle_next;
    logic [sfr_pkg::TICK_W-1:0] since_reg, since_next;
    logic                      wait_reg,    wait_next;
    logic                      pending_reg, pending_next;
    logic                      tout_reg,    tout_next;

    logic [IDX_W-1:0]           idx_base;
    logic [7:0]                 sum_base;
    logic [EXT_W-1:0]           idx_ext;
    logic [EXT_W-1:0]           csum_pos;
    logic [7:0]                 expect_sum;
    logic [sfr_pkg::TICK_W-1:0] since_inc;
    sfr_pkg::event_t            ev;
    logic [7:0]                 dbyte;
    logic [5:0]                 pos;

    always_comb
    begin
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        flags_next   = flags_reg;
        major_next   = major_reg;
        minor_next   = minor_reg;
        length_next  = length_reg;
        idle_next    = idle_reg;
        since_next   = since_reg;
        wait_next    = wait_reg;
        pending_next = pending_reg;
        tout_next    = tout_reg;
        ev           = sfr_pkg::EV_NONE;
        dbyte        = 8'd0;
        pos          = 6'd0;
        idx_base     = idx_reg;
        sum_base     = sum_reg;
        idx_ext      = EXT_W'(idx_reg);
        csum_pos     = EXT_W'(sfr_pkg::HEADER_BYTES) + {1'b0, length_reg};
        expect_sum   = 8'd0;
        since_inc    = since_reg;

        case (req_type)
            sfr_pkg::REQ_TICK:
            begin
                if (idle_reg != sfr_pkg::TICK_MAX)
                    idle_next = idle_reg + 1'b1;
                if (wait_reg)
                begin
                    if (since_reg != sfr_pkg::TICK_MAX)
                        since_inc = since_reg + 1'b1;
                    since_next = since_inc;
                    if (since_inc > {1'b0, cfg.timeout_ms})
                    begin
                        wait_next = 1'b0;
                        tout_next = 1'b1;
                        ev        = sfr_pkg::EV_TIMEOUT;
                    end
                end
            end

            sfr_pkg::REQ_SENT:
            begin
                idx_next     = '0;
                sum_next     = 8'd0;
                idle_next    = '0;
                tout_next    = 1'b0;
                pending_next = 1'b0;
                since_next   = '0;
                wait_next    = 1'b1;
            end

            sfr_pkg::REQ_BYTE:
            begin
                // Drop a half-built frame after a long gap
                if (idle_reg > {1'b0, cfg.timeout_ms})
                begin
                    idx_base     = '0;
                    sum_base     = 8'd0;
                    tout_next    = 1'b0;
                    pending_next = 1'b0;
                end
                idle_next = '0;
                idx_next  = idx_base;
                sum_next  = sum_base;
                idx_ext   = EXT_W'(idx_base);

                if (idx_base == '0 && rx_byte != cfg.start_byte)
                begin
                    ev = sfr_pkg::EV_IGNORED;
                end
                else
                begin
                    dbyte = rx_byte;
                    pos   = idx_ext[5:0];
                    if (idx_ext >= EXT_W'(sfr_pkg::HEADER_BYTES) && idx_ext == csum_pos)
                    begin
                        // Checksum byte: compare, do not accumulate
                        expect_sum   = cfg.start_byte - sum_base;
                        idx_next     = '0;
                        sum_next     = 8'd0;
                        tout_next    = 1'b0;
                        pending_next = 1'b0;
                        if (rx_byte == expect_sum)
                        begin
                            wait_next    = 1'b0;
                            pending_next = 1'b1;
                            ev           = sfr_pkg::EV_GOOD;
                        end
                        else
                        begin
                            ev = sfr_pkg::EV_BAD_CSUM;
                        end
                    end
                    else
                    begin
                        sum_next = sum_base + rx_byte;
                        idx_next = idx_base + 1'b1;
                        ev       = sfr_pkg::EV_STORED;
                        case (idx_ext)
                            EXT_W'(sfr_pkg::POS_FLAGS):  flags_next  = rx_byte;
                            EXT_W'(sfr_pkg::POS_MAJOR):  major_next  = rx_byte;
                            EXT_W'(sfr_pkg::POS_MINOR):  minor_next  = rx_byte;
                            EXT_W'(sfr_pkg::POS_LENGTH): length_next = rx_byte;
                            default:                     flags_next  = flags_reg;
                        endcase
                        if (idx_ext == EXT_W'(sfr_pkg::POS_LENGTH))
                        begin
                            if (major_reg != cfg.proto_major ||
                                minor_reg != cfg.proto_minor)
                            begin
                                idx_next     = '0;
                                sum_next     = 8'd0;
                                tout_next    = 1'b0;
                                pending_next = 1'b0;
                                ev           = sfr_pkg::EV_BAD_VER;
                            end
                            else if (rx_byte > MAX_LEN)
                            begin
                                idx_next     = '0;
                                sum_next     = 8'd0;
                                tout_next    = 1'b0;
                                pending_next = 1'b0;
                                ev           = sfr_pkg::EV_TOO_LONG;
                            end
                        end
                    end
                end
            end

            default:
            begin
                ev = sfr_pkg::EV_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            sum_reg     <= 8'd0;
            flags_reg   <= 8'd0;
            major_reg   <= 8'd0;
            minor_reg   <= 8'd0;
            length_reg  <= 8'd0;
            idle_reg    <= '0;
            since_reg   <= '0;
            wait_reg    <= 1'b0;
            pending_reg <= 1'b0;
            tout_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            idx_reg     <= idx_next;
            sum_reg     <= sum_next;
            flags_reg   <= flags_next;
            major_reg   <= major_next;
            minor_reg   <= minor_next;
            length_reg  <= length_next;
            idle_reg    <= idle_next;
            since_reg   <= since_next;
            wait_reg    <= wait_next;
            pending_reg <= pending_next;
            tout_reg    <= tout_next;
        end
    end

    assign res.event_res          = ev;
    assign res.data_byte          = dbyte;
    assign res.byte_position      = pos;
    assign res.frame_flags        = flags_next;
    assign res.frame_length       = length_next[5:0];
    assign res.waiting_response   = wait_next;
    assign res.response_pending   = pending_next;
    assign res.response_timed_out = tout_next;

endmodule

// ===== src/serial_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver top level
// Length-prefixed frame receiver with subtractive checksum and timeouts.
// ----------------------------------------------------------------------------
// The receiver takes one transaction per clock on the item channel: a received
// UART byte, a one-millisecond tick or a request-sent event. Each transaction
// gives exactly one result transaction, in order. An accepted item lands in the
// input register; once the result slot is free or drains, the frame engine
// updates its state and the result register captures the outcome on the
// same clock. Sustained rate is one item per cycle while the result sink
// keeps up; the item channel keeps taking items while a finished result
// waits, and stalls only when both the input and the result register are
// full and the result sink holds off. Frames are start byte, flags, version
// major, version minor, length, payload and a checksum byte equal to the
// start byte minus the sum of all earlier bytes, modulo 256. Lengths above
// MAX_PAYLOAD are reported and dropped. Write configuration only while the
// receiver is idle.
// ----------------------------------------------------------------------------
module serial_frame_receiver_top #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  wr_data,
    sfr_item_if.sink                        item,
    sfr_result_if.source                    result
);

    sfr_pkg::cfg_t cfg;
    sfr_pkg::res_t step_res;

    // Input register
    logic       in_valid_reg;
    logic [1:0] in_req_reg;
    logic [7:0] in_byte_reg;

    // Result register
    logic          out_valid_reg;
    sfr_pkg::res_t out_res_reg;

    logic advance;

    // Advance the registered item whenever the result slot is free or drains now
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    sfr_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    sfr_frame_engine #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_frame_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (advance),
        .req_type (in_req_reg),
        .rx_byte  (in_byte_reg),
        .cfg      (cfg),
        .res      (step_res)
    );

    // Hold the input payload until the engine consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_req_reg  <= item.req_type;
            in_byte_reg <= item.rx_byte;
        end
    end

    // Result slot: load on advance, drop once the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.event_res          = out_res_reg.event_res;
    assign result.data_byte          = out_res_reg.data_byte;
    assign result.byte_position      = out_res_reg.byte_position;
    assign result.frame_flags        = out_res_reg.frame_flags;
    assign result.frame_length       = out_res_reg.frame_length;
    assign result.waiting_response   = out_res_reg.waiting_response;
    assign result.response_pending   = out_res_reg.response_pending;
    assign result.response_timed_out = out_res_reg.response_timed_out;

endmodule

// ===== src/sfr_port_checker.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver port checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "serial_frame_receiver_top_macros.svh"

module sfr_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] event_res,
    input logic [7:0] data_byte,
    input logic [5:0] byte_position,
    input logic       waiting_response,
    input logic       response_pending,
    input logic       response_timed_out
);

    logic no_byte_event;

    assign no_byte_event = event_res == sfr_pkg::EV_NONE ||
                           event_res == sfr_pkg::EV_IGNORED ||
                           event_res == sfr_pkg::EV_TIMEOUT;

    // A stalled result holds its transaction
    `SFR_ASSERT_NEXT(a_stall_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(event_res) && $stable(data_byte) && $stable(byte_position))

    // Only a taken byte reports a data byte and position
    `SFR_ASSERT_NOW(a_no_byte_quiet, clk, rst_n, res_valid && no_byte_event, data_byte == 8'd0 && byte_position == 6'd0)

    // A good frame ends the wait and marks a response pending
    `SFR_ASSERT_NOW(a_good_frame, clk, rst_n, res_valid && event_res == sfr_pkg::EV_GOOD, response_pending && !waiting_response)

    // A response timeout ends the wait and raises the flag
    `SFR_ASSERT_NOW(a_timeout, clk, rst_n, res_valid && event_res == sfr_pkg::EV_TIMEOUT, response_timed_out && !waiting_response)

endmodule

bind serial_frame_receiver_top sfr_port_checker u_port_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (result.valid),
    .res_ready          (result.ready),
    .event_res          (result.event_res),
    .data_byte          (result.data_byte),
    .byte_position      (result.byte_position),
    .waiting_response   (result.waiting_response),
    .response_pending   (result.response_pending),
    .response_timed_out (result.response_timed_out)
);

// ===== tb/sfr_checker.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver checker
// Watches the item, result and configuration ports, predicts each result
// and compares it field by field with what the receiver returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_checker #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  wr_data,
    sfr_item_if                             item,
    sfr_result_if                           result,
    output int                              mismatches,
    output int                              outstanding
);

    localparam sfr_pkg::cfg_t CFG_AT_RESET = '{
        start_byte: 8'd252, proto_major: 8'd0, proto_minor: 8'd0, timeout_ms: 16'd1000
    };

    sfr_pkg::cfg_t cfg_now;
    logic [5:0]    frame_idx;
    logic [7:0]    run_sum;
    logic [7:0]    held_flags;
    logic [7:0]    held_major;
    logic [7:0]    held_minor;
    logic [7:0]    held_len;
    logic [16:0]   idle_cnt;
    logic [16:0]   req_cnt;
    logic          wait_resp;
    logic          resp_pend;
    logic          resp_tmo;

    sfr_pkg::res_t receiver_outcomes[$];
    sfr_pkg::res_t seen;
    sfr_pkg::res_t want;

    task automatic report_mismatch(input string msg);
        $display("[%0t] sfr_checker: %s", $time, msg);
        mismatches++;
    endtask

    task automatic restart_frame();
        frame_idx = '0;
        run_sum   = '0;
        idle_cnt  = '0;
        resp_tmo  = 1'b0;
        resp_pend = 1'b0;
    endtask

    task automatic advance_receiver(input logic [1:0] kind, input logic [7:0] b,
                                    output sfr_pkg::res_t r);
        sfr_pkg::event_t ev;
        logic [7:0]      taken;
        logic [5:0]      pos;
        logic [7:0]      csum_want;
        ev    = sfr_pkg::EV_NONE;
        taken = '0;
        pos   = '0;
        if (kind == sfr_pkg::REQ_TICK) begin
            if (idle_cnt != sfr_pkg::TICK_MAX) idle_cnt++;
            if (wait_resp) begin
                if (req_cnt != sfr_pkg::TICK_MAX) req_cnt++;
                if (req_cnt > {1'b0, cfg_now.timeout_ms}) begin
                    wait_resp = 1'b0;
                    resp_tmo  = 1'b1;
                    ev        = sfr_pkg::EV_TIMEOUT;
                end
            end
        end else if (kind == sfr_pkg::REQ_SENT) begin
            restart_frame();
            req_cnt   = '0;
            wait_resp = 1'b1;
        end else if (kind == sfr_pkg::REQ_BYTE) begin
            if (idle_cnt > {1'b0, cfg_now.timeout_ms}) restart_frame();
            idle_cnt = '0;
            if (frame_idx == 0 && b != cfg_now.start_byte) begin
                ev = sfr_pkg::EV_IGNORED;
            end else begin
                pos   = frame_idx;
                taken = b;
                if (frame_idx >= sfr_pkg::HEADER_BYTES &&
                    frame_idx == sfr_pkg::HEADER_BYTES + held_len) begin
                    csum_want = cfg_now.start_byte - run_sum;
                    restart_frame();
                    if (b == csum_want) begin
                        wait_resp = 1'b0;
                        resp_pend = 1'b1;
                        ev        = sfr_pkg::EV_GOOD;
                    end else begin
                        ev = sfr_pkg::EV_BAD_CSUM;
                    end
                end else begin
                    run_sum = run_sum + b;
                    case (frame_idx)
                        sfr_pkg::POS_FLAGS:  held_flags = b;
                        sfr_pkg::POS_MAJOR:  held_major = b;
                        sfr_pkg::POS_MINOR:  held_minor = b;
                        sfr_pkg::POS_LENGTH: held_len   = b;
                        default: ;
                    endcase
                    frame_idx++;
                    ev = sfr_pkg::EV_STORED;
                    if (frame_idx == sfr_pkg::HEADER_BYTES) begin
                        if (held_major != cfg_now.proto_major ||
                            held_minor != cfg_now.proto_minor) begin
                            restart_frame();
                            ev = sfr_pkg::EV_BAD_VER;
                        end else if (held_len > MAX_PAYLOAD) begin
                            restart_frame();
                            ev = sfr_pkg::EV_TOO_LONG;
                        end
                    end
                end
            end
        end
        // code 3 falls through: no state change, no event
        r.event_res          = ev;
        r.data_byte          = taken;
        r.byte_position      = pos;
        r.frame_flags        = held_flags;
        r.frame_length       = held_len[5:0];
        r.waiting_response   = wait_resp;
        r.response_pending   = resp_pend;
        r.response_timed_out = resp_tmo;
    endtask

    task automatic compare_result(input sfr_pkg::res_t got, input sfr_pkg::res_t exp_r);
        if (got.event_res != exp_r.event_res)
            report_mismatch($sformatf("event_res %0d, predicted %0d",
                                      got.event_res, exp_r.event_res));
        if (got.data_byte != exp_r.data_byte)
            report_mismatch($sformatf("data_byte %0h, predicted %0h",
                                      got.data_byte, exp_r.data_byte));
        if (got.byte_position != exp_r.byte_position)
            report_mismatch($sformatf("byte_position %0d, predicted %0d",
                                      got.byte_position, exp_r.byte_position));
        if (got.frame_flags != exp_r.frame_flags)
            report_mismatch($sformatf("frame_flags %0h, predicted %0h",
                                      got.frame_flags, exp_r.frame_flags));
        if (got.frame_length != exp_r.frame_length)
            report_mismatch($sformatf("frame_length %0d, predicted %0d",
                                      got.frame_length, exp_r.frame_length));
        if (got.waiting_response != exp_r.waiting_response)
            report_mismatch($sformatf("waiting_response %0b, predicted %0b",
                                      got.waiting_response, exp_r.waiting_response));
        if (got.response_pending != exp_r.response_pending)
            report_mismatch($sformatf("response_pending %0b, predicted %0b",
                                      got.response_pending, exp_r.response_pending));
        if (got.response_timed_out != exp_r.response_timed_out)
            report_mismatch($sformatf("response_timed_out %0b, predicted %0b",
                                      got.response_timed_out, exp_r.response_timed_out));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_now    = CFG_AT_RESET;
            restart_frame();
            held_flags = '0;
            held_major = '0;
            held_minor = '0;
            held_len   = '0;
            req_cnt    = '0;
            wait_resp  = 1'b0;
            receiver_outcomes.delete();
            mismatches  = 0;
            outstanding = 0;
        end else begin
            if (result.valid && result.ready) begin
                seen.event_res          = sfr_pkg::event_t'(result.event_res);
                seen.data_byte          = result.data_byte;
                seen.byte_position      = result.byte_position;
                seen.frame_flags        = result.frame_flags;
                seen.frame_length       = result.frame_length;
                seen.waiting_response   = result.waiting_response;
                seen.response_pending   = result.response_pending;
                seen.response_timed_out = result.response_timed_out;
                if (receiver_outcomes.size() == 0)
                    report_mismatch($sformatf("result with event %0d and nothing predicted",
                                              seen.event_res));
                else
                    compare_result(seen, receiver_outcomes.pop_front());
            end
            if (item.valid && item.ready) begin
                advance_receiver(item.req_type, item.rx_byte, want);
                receiver_outcomes.push_back(want);
            end
            if (wr_en) begin
                case (wr_index)
                    sfr_pkg::CFG_START_BYTE:  cfg_now.start_byte  = wr_data[7:0];
                    sfr_pkg::CFG_PROTO_MAJOR: cfg_now.proto_major = wr_data[7:0];
                    sfr_pkg::CFG_PROTO_MINOR: cfg_now.proto_minor = wr_data[7:0];
                    sfr_pkg::CFG_TIMEOUT_MS:  cfg_now.timeout_ms  = wr_data[15:0];
                    default: ;
                endcase
            end
            outstanding = receiver_outcomes.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver testbench
// Drives bytes, ticks and request events into the receiver under several
// register settings, with random gaps and stalls on both channels, and
// leaves prediction and comparison to the checker beside the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int         MAX_PAYLOAD      = 32;
    localparam logic [1:0] REQ_UNUSED       = 2'd3;   // no meaning, receiver drops it
    localparam int         CYCLE_LIMIT      = 400000;
    localparam int         LONG_HOLD_CYCLES = 60;
    localparam int         SETTLE_CYCLES    = 4;

    logic                            clk;
    logic                            rst_n;
    logic                            wr_en;
    logic [sfr_pkg::CFG_INDEX_W-1:0] wr_index;
    logic [sfr_pkg::CFG_DATA_W-1:0]  wr_data;

    int            mismatches;
    int            outstanding;
    int            items_done;
    sfr_pkg::cfg_t cur_cfg;        // register values as last written, used to build frames
    bit            quiet;          // no idling on either side when set
    bit            long_hold_req;  // ask the result side for one long hold-off

    sfr_item_if   item_ch();
    sfr_result_if result_ch();

    serial_frame_receiver_top #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .item     (item_ch),
        .result   (result_ch)
    );

    sfr_checker #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .item        (item_ch),
        .result      (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bound the run; a hang anywhere ends here.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // Result side: take results, with short random stalls, calm stretches,
    // and one long hold-off on request so the receiver backs up into its input.
    initial
    begin
        result_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                // calm stretch: hold ready high for a while
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one transaction and hold it until it is taken. Valid stays high on
    // return so back-to-back transactions follow without a gap.
    task automatic send_item(input logic [1:0] kind, input logic [7:0] b, input bit counted);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.req_type <= kind;
        item_ch.rx_byte  <= b;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        @(negedge clk);
        if (counted) items_done++;
    endtask

    // Mostly random bytes, with the two extremes showing up often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Tick burst bound: for a timeout up to 38, a little past it so both sides are hit; else 40.
    function automatic int tick_span();
        return (cur_cfg.timeout_ms > 16'd38) ? 40 : int'(cur_cfg.timeout_ms) + 2;
    endfunction

    task automatic send_ticks(input int count);
        repeat (count) send_item(sfr_pkg::REQ_TICK, 8'($urandom), 1'b1);
    endtask

    // Send a frame built from the current registers. A header the receiver will
    // reject ends the frame after the length byte.
    task automatic send_frame(input logic [7:0] flags, input logic [7:0] maj,
                              input logic [7:0] mnr, input logic [7:0] len,
                              input bit bad_csum, input bit with_ticks);
        logic [7:0] sum;
        logic [7:0] b;
        sum = cur_cfg.start_byte + flags + maj + mnr + len;
        send_item(sfr_pkg::REQ_BYTE, cur_cfg.start_byte, 1'b1);
        send_item(sfr_pkg::REQ_BYTE, flags, 1'b1);
        send_item(sfr_pkg::REQ_BYTE, maj, 1'b1);
        send_item(sfr_pkg::REQ_BYTE, mnr, 1'b1);
        send_item(sfr_pkg::REQ_BYTE, len, 1'b1);
        if (maj != cur_cfg.proto_major || mnr != cur_cfg.proto_minor || len > MAX_PAYLOAD)
            return;
        for (int i = 0; i < len; i++)
        begin
            // drop a tick burst into the payload now and then; a long one restarts
            if (with_ticks && $urandom_range(0, 15) == 0)
                send_ticks($urandom_range(1, tick_span()));
            b   = pick_byte();
            sum = sum + b;
            send_item(sfr_pkg::REQ_BYTE, b, 1'b1);
        end
        b = cur_cfg.start_byte - sum;
        if (bad_csum) b = b ^ 8'($urandom_range(1, 255));
        send_item(sfr_pkg::REQ_BYTE, b, 1'b1);
    endtask

    // Random traffic: mostly well-formed frames with random content, then
    // rejected headers, tick bursts, requests, cut-off frames and noise.
    task automatic run_traffic(input int target);
        int         pick;
        logic [7:0] maj;
        logic [7:0] mnr;
        logic [7:0] len;
        items_done = 0;
        while (items_done < target)
        begin
            pick = $urandom_range(0, 99);
            maj  = cur_cfg.proto_major;
            mnr  = cur_cfg.proto_minor;
            len  = ($urandom_range(0, 9) == 0) ? 8'(MAX_PAYLOAD) : 8'($urandom_range(0, 12));
            if (pick < 50)
            begin
                send_frame(pick_byte(), maj, mnr, len, $urandom_range(0, 7) == 0, 1'b1);
            end
            else if (pick < 58)
            begin
                if ($urandom_range(0, 1))
                    maj = maj ^ 8'($urandom_range(1, 255));
                else
                    mnr = mnr ^ 8'($urandom_range(1, 255));
                send_frame(pick_byte(), maj, mnr, len, 1'b0, 1'b0);
            end
            else if (pick < 64)
            begin
                send_frame(pick_byte(), maj, mnr, 8'($urandom_range(MAX_PAYLOAD + 1, 255)),
                           1'b0, 1'b0);
            end
            else if (pick < 76)
            begin
                send_ticks($urandom_range(1, tick_span()));
            end
            else if (pick < 82)
            begin
                send_item(sfr_pkg::REQ_SENT, pick_byte(), 1'b1);
            end
            else if (pick < 90)
            begin
                // cut-off frame: the next frame's bytes land mid-frame
                send_item(sfr_pkg::REQ_BYTE, cur_cfg.start_byte, 1'b1);
                repeat ($urandom_range(1, 4)) send_item(sfr_pkg::REQ_BYTE, pick_byte(), 1'b1);
            end
            else
            begin
                send_item($urandom_range(0, 1) ? REQ_UNUSED : 2'(sfr_pkg::REQ_BYTE),
                          8'($urandom), 1'b0);
            end
        end
    endtask

    // Drop valid and wait for every predicted result to come back.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    // Write all four registers on consecutive cycles; the receiver is idle.
    task automatic program_config(input logic [7:0] sb, input logic [7:0] maj,
                                  input logic [7:0] mnr, input logic [15:0] tmo);
        cur_cfg.start_byte  = sb;
        cur_cfg.proto_major = maj;
        cur_cfg.proto_minor = mnr;
        cur_cfg.timeout_ms  = tmo;
        wr_en    <= 1'b1;
        wr_index <= sfr_pkg::CFG_START_BYTE;
        wr_data  <= {8'h00, sb};
        @(negedge clk);
        wr_index <= sfr_pkg::CFG_PROTO_MAJOR;
        wr_data  <= {8'h00, maj};
        @(negedge clk);
        wr_index <= sfr_pkg::CFG_PROTO_MINOR;
        wr_data  <= {8'h00, mnr};
        @(negedge clk);
        wr_index <= sfr_pkg::CFG_TIMEOUT_MS;
        wr_data  <= tmo;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    initial
    begin
        // Hold every input at a known value through reset.
        rst_n            = 1'b0;
        wr_en            = 1'b0;
        wr_index         = sfr_pkg::CFG_START_BYTE;
        wr_data          = '0;
        item_ch.valid    = 1'b0;
        item_ch.req_type = sfr_pkg::REQ_BYTE;
        item_ch.rx_byte  = '0;
        quiet            = 1'b0;
        long_hold_req    = 1'b0;
        cur_cfg.start_byte  = 8'd252;
        cur_cfg.proto_major = 8'd0;
        cur_cfg.proto_minor = 8'd0;
        cur_cfg.timeout_ms  = 16'd1000;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part on the reset register values.
        send_item(REQ_UNUSED, 8'hA5, 1'b1);                    // unused code: no event
        send_item(sfr_pkg::REQ_BYTE, 8'h00, 1'b1);             // hunting: ignored
        send_item(sfr_pkg::REQ_BYTE, 8'hFF, 1'b1);
        send_item(sfr_pkg::REQ_SENT, 8'h5A, 1'b1);             // start waiting for a response
        send_frame(8'hFF, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0);    // empty payload, good
        send_frame(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0);   // too long, length wraps to 63
        send_frame(8'h3C, 8'h00, 8'h01, 8'd2, 1'b0, 1'b0);    // minor version off
        send_frame(8'hC3, 8'h07, 8'h00, 8'd2, 1'b0, 1'b0);    // major version off
        send_frame(8'h5A, 8'h00, 8'h00, 8'd1, 1'b1, 1'b0);    // checksum off

        // Reset timeout of 1000: a response timeout, then a byte after the long
        // gap restarts the frame that was left open.
        send_item(sfr_pkg::REQ_SENT, 8'h00, 1'b1);
        send_item(sfr_pkg::REQ_BYTE, cur_cfg.start_byte, 1'b1);
        send_ticks(1001);
        send_frame(8'h81, 8'h00, 8'h00, 8'd3, 1'b0, 1'b0);
        run_traffic(100);
        settle();

        // Zero timeout: any tick between bytes restarts, any tick times out a request.
        program_config(8'h00, 8'hFF, 8'hFF, 16'd0);
        run_traffic(200);
        settle();

        // Largest timeout, with one long hold-off on the result side.
        program_config(8'hFF, 8'h00, 8'hFF, 16'hFFFF);
        long_hold_req = 1'b1;
        run_traffic(200);
        settle();

        program_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(3, 20)));
        run_traffic(200);
        settle();

        // Last part runs at full rate with no idling.
        quiet = 1'b1;
        program_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(1, 6)));
        run_traffic(100);
        settle();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
